FILE: hdl/breakthrough_curve_moments_unit_defines.svh
// ----------------------------------------------------------------------------
// Breakthrough curve moments: assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef BREAKTHROUGH_CURVE_MOMENTS_UNIT_DEFINES_SVH
`define BREAKTHROUGH_CURVE_MOMENTS_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define BCM_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bcm check failed");

// next-cycle implication, disabled in reset
`define BCM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bcm check failed");

`endif

FILE: hdl/bcm_pkg.sv
// ----------------------------------------------------------------------------
// bcm_pkg
// Constants and shared request/response types for the moments unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bcm_pkg;

	localparam int SAMPLE_DEPTH = 1024;
	localparam int ADDR_W       = $clog2(SAMPLE_DEPTH);
	localparam int CNT_W        = ADDR_W + 1;
	localparam int DIV_STEPS    = 80;
	localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
	localparam logic [31:0] MASS_RESET = 32'h0001_0000;

	// shared multiplier request and response
	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] b;
	} bcm_mul_req_t;

	typedef struct packed {
		logic         done;
		logic [127:0] prod;
	} bcm_mul_rsp_t;

	// shared divider request and response
	typedef struct packed {
		logic        start;
		logic [63:0] num;
		logic [63:0] den;
	} bcm_div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quot;
		logic        over;
	} bcm_div_rsp_t;

endpackage

`default_nettype wire

FILE: hdl/bcm_mul.sv
// ----------------------------------------------------------------------------
// bcm_mul
// 64x64 multiplier built from one 32x32 partial product per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bcm_mul (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire bcm_pkg::bcm_mul_req_t req,
	output bcm_pkg::bcm_mul_rsp_t      rsp
);

	logic [63:0]  a_q;
	logic [63:0]  b_q;
	logic [127:0] acc_q;
	logic [63:0]  prod_q;
	logic [1:0]   sh_q;
	logic         pv_q;
	logic [2:0]   step_q;
	logic         busy_q;
	logic         done_q;

	logic [31:0]  a_half;
	logic [31:0]  b_half;
	logic [127:0] addend;

	// partial product operand select
	always_comb begin
		a_half = step_q[1] ? a_q[63:32] : a_q[31:0];
		b_half = step_q[0] ? b_q[63:32] : b_q[31:0];
		case (sh_q)
			2'd0:    addend = {64'd0, prod_q};
			2'd1:    addend = {32'd0, prod_q, 32'd0};
			default: addend = {prod_q, 64'd0};
		endcase
	end

	// one partial product per cycle, accumulated in the following cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			pv_q   <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
				pv_q   <= 1'b0;
			end else if (busy_q) begin
				pv_q <= (step_q != 3'd4);
				if (step_q == 3'd4) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q + 3'd1;
				end
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= '0;
		end else if (busy_q) begin
			prod_q <= {32'd0, a_half} * {32'd0, b_half};
			sh_q   <= {1'b0, step_q[1]} + {1'b0, step_q[0]};
			if (pv_q) begin
				acc_q <= acc_q + addend;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = acc_q;

endmodule

`default_nettype wire

FILE: hdl/bcm_div.sv
// ----------------------------------------------------------------------------
// bcm_div
// Restoring divider, floor(num * 2^16 / den), one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bcm_div (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire bcm_pkg::bcm_div_req_t req,
	output bcm_pkg::bcm_div_rsp_t      rsp
);

	logic [63:0] num_q;
	logic [63:0] den_q;
	logic [63:0] r_q;
	logic [63:0] q_q;
	logic        over_q;
	logic [bcm_pkg::DIV_CNT_W-1:0] cnt_q;
	logic        busy_q;
	logic        done_q;

	logic        in_bit;
	logic [64:0] r_shift;
	logic        take;

	// one restoring step
	always_comb begin
		in_bit  = (cnt_q >= bcm_pkg::DIV_CNT_W'(16)) ? num_q[63] : 1'b0;
		r_shift = {r_q, in_bit};
		take    = r_q[63] || (r_shift >= {1'b0, den_q});
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= bcm_pkg::DIV_CNT_W'(bcm_pkg::DIV_STEPS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - bcm_pkg::DIV_CNT_W'(1);
				end
			end
		end
	end

	// remainder and quotient
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q  <= req.num;
			den_q  <= req.den;
			r_q    <= '0;
			q_q    <= '0;
			over_q <= 1'b0;
		end else if (busy_q) begin
			num_q  <= {num_q[62:0], 1'b0};
			r_q    <= take ? (r_shift[63:0] - den_q) : r_shift[63:0];
			q_q    <= {q_q[62:0], take};
			over_q <= over_q | q_q[63];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = q_q;
	assign rsp.over = over_q;

endmodule

`default_nettype wire

FILE: hdl/breakthrough_curve_moments_unit.sv
// ----------------------------------------------------------------------------
// breakthrough_curve_moments_unit
// Trapezoid temporal moments of a tracer breakthrough curve.
// ----------------------------------------------------------------------------
// Usage:
//   s_tdata = {concentration Q16.16, sample_time}, s_tlast marks the final
//   sample. One result beat on m_* follows each final sample.
//   cfg_valid/cfg_data write injected_mass; write only while idle.
// Work per sample:
//   A first sample is taken in the idle state. A later sample adds one, two
//   or four products on the shared 64x64 multiplier.
//   A final sample adds a store scan (read, then check) per stored sample up
//   to the first hit, up to three 80-step divisions, at most one square and
//   the output state.
//   s_tready is low while a sample is being worked on.
// Reset: curve state clears, injected_mass returns to 1.0, no result pending.
//   The sample store is not cleared; only entries of the current curve are read.
// Stall: the result sits in an output register; new samples are taken while it
//   waits, but the next result waits until the previous beat is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module breakthrough_curve_moments_unit (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// configuration: injected_mass
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [31:0]  cfg_data,
	// samples: [31:0] sample_time, [63:32] concentration
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [63:0]  s_tdata,
	input  wire logic         s_tlast,
	// results: [31:0] arrival_time, [63:32] peak_level, [95:64] peak_at,
	// [143:96] mean_time, [207:144] time_variance, [239:208] recovery,
	// [240] overflow, [247:241] zero
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [247:0]      m_tdata
);

	localparam int AW = bcm_pkg::ADDR_W;
	localparam int CW = bcm_pkg::CNT_W;
	localparam logic [63:0] MAX64 = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

	typedef enum logic [3:0] {
		ST_IDLE, ST_P0, ST_P1, ST_P2, ST_REC, ST_SCAN_RD, ST_SCAN_CHK,
		ST_DIV_MEAN, ST_DIV_E2, ST_MSQ, ST_DIV_REC, ST_OUT
	} state_t;

	state_t state_q;
	logic   issued_q;

	// curve state
	logic [CW-1:0] count_q;
	logic [63:0]   m0_q, m1_q, m2_q, rsum_q;
	logic [31:0]   peak_q, peakt_q, prevt_q, prevl_q;
	logic          ovf_q;
	logic [31:0]   mass_q;

	// per-sample working registers
	logic [31:0]   c_q, dt_q;
	logic [32:0]   tsum_q;
	logic [32:0]   csum_q;
	logic          last_q;
	logic [63:0]   p0_q, p1_q;

	// final pass registers
	logic [CW-1:0] scan_q;
	logic [31:0]   arrival_q;
	logic [47:0]   mean_q;
	logic [63:0]   e2_q, var_q;
	logic [31:0]   recov_q;

	// sample store
	logic [31:0]   time_mem [bcm_pkg::SAMPLE_DEPTH];
	logic [31:0]   level_mem [bcm_pkg::SAMPLE_DEPTH];
	logic [31:0]   rd_time_q, rd_level_q;

	bcm_pkg::bcm_mul_req_t mul_req;
	bcm_pkg::bcm_mul_rsp_t mul_rsp;
	bcm_pkg::bcm_div_req_t div_req;
	bcm_pkg::bcm_div_rsp_t div_rsp;

	logic          accept;
	logic          first;
	logic [31:0]   in_t, in_c;
	logic [31:0]   dt_now;
	logic [32:0]   csum_now, tsum_now;
	logic          store_ok;
	logic          out_load;

	logic          mul_sat;
	logic [63:0]   mul_val;
	logic [63:0]   acc_sel;
	logic [64:0]   acc_sum;
	logic          acc_sat;
	logic [63:0]   acc_val;

	logic [38:0]   lvl100;
	logic          hit;
	logic [62:0]   q_half;
	logic          msq_sat;
	logic [63:0]   msq;
	logic [63:0]   dpos, dneg;
	logic [63:0]   var_now;
	logic          var_sat;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign in_t      = s_tdata[31:0];
	assign in_c      = s_tdata[63:32];
	assign first     = (count_q == '0);
	assign store_ok  = (count_q < CW'(bcm_pkg::SAMPLE_DEPTH));
	assign out_load  = (state_q == ST_OUT) && (!m_tvalid || m_tready);

	// interval terms of the incoming sample
	always_comb begin
		dt_now   = (in_t >= prevt_q) ? (in_t - prevt_q) : 32'd0;
		csum_now = {1'b0, in_c} + {1'b0, prevl_q};
		tsum_now = {1'b0, in_t} + {1'b0, prevt_q};
	end

	// shared unit requests
	always_comb begin
		mul_req = '0;
		div_req = '0;
		case (state_q)
			ST_P0: begin
				mul_req.a = {31'd0, csum_q};
				mul_req.b = {32'd0, dt_q};
			end
			ST_P1: begin
				mul_req.a = p0_q;
				mul_req.b = {31'd0, tsum_q};
			end
			ST_P2: begin
				mul_req.a = p1_q;
				mul_req.b = {31'd0, tsum_q};
			end
			ST_REC: begin
				mul_req.a = {32'd0, c_q};
				mul_req.b = {32'd0, dt_q};
			end
			ST_MSQ: begin
				mul_req.a = {16'd0, mean_q};
				mul_req.b = {16'd0, mean_q};
			end
			ST_DIV_MEAN: begin
				div_req.num = m1_q;
				div_req.den = m0_q;
			end
			ST_DIV_E2: begin
				div_req.num = m2_q;
				div_req.den = m0_q;
			end
			ST_DIV_REC: begin
				div_req.num = rsum_q;
				div_req.den = {32'd0, mass_q};
			end
			default: begin
				mul_req = '0;
			end
		endcase
		mul_req.start = !issued_q && (state_q == ST_P0 || state_q == ST_P1 ||
			state_q == ST_P2 || state_q == ST_REC || state_q == ST_MSQ);
		div_req.start = !issued_q && (state_q == ST_DIV_MEAN ||
			state_q == ST_DIV_E2 || state_q == ST_DIV_REC);
	end

	// saturating product and accumulate
	always_comb begin
		mul_sat = |mul_rsp.prod[127:64];
		mul_val = mul_sat ? MAX64 : mul_rsp.prod[63:0];
		case (state_q)
			ST_P0:   acc_sel = m0_q;
			ST_P1:   acc_sel = m1_q;
			ST_P2:   acc_sel = m2_q;
			default: acc_sel = rsum_q;
		endcase
		acc_sum = {1'b0, acc_sel} + {1'b0, mul_val};
		acc_sat = acc_sum[64];
		acc_val = acc_sat ? MAX64 : acc_sum[63:0];
	end

	// scan test, quotient trimming and variance
	always_comb begin
		lvl100 = {7'd0, rd_level_q} * 39'd100;
		hit    = lvl100 > {7'd0, peak_q};
		q_half = div_rsp.quot[63:1];
		msq_sat = |mul_rsp.prod[127:80];
		msq     = msq_sat ? MAX64 : mul_rsp.prod[79:16];
		dpos    = e2_q - msq;
		dneg    = msq - e2_q;
		var_sat = 1'b0;
		if (e2_q >= msq) begin
			if (dpos[63]) begin
				var_now = 64'h7FFF_FFFF_FFFF_FFFF;
				var_sat = 1'b1;
			end else begin
				var_now = dpos;
			end
		end else begin
			if (dneg > 64'h8000_0000_0000_0000) begin
				var_now = 64'h8000_0000_0000_0000;
				var_sat = 1'b1;
			end else begin
				var_now = 64'd0 - dneg;
			end
		end
	end

	// sequencer, curve state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			issued_q <= 1'b0;
			count_q  <= '0;
			m0_q     <= '0;
			m1_q     <= '0;
			m2_q     <= '0;
			rsum_q   <= '0;
			peak_q   <= '0;
			peakt_q  <= '0;
			prevt_q  <= '0;
			prevl_q  <= '0;
			ovf_q    <= 1'b0;
			mass_q   <= bcm_pkg::MASS_RESET;
			m_tvalid <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				mass_q <= cfg_data;
			end
			if (out_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			if (mul_req.start || div_req.start) begin
				issued_q <= 1'b1;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						c_q    <= in_c;
						dt_q   <= dt_now;
						csum_q <= csum_now;
						tsum_q <= tsum_now;
						last_q <= s_tlast;
						if (store_ok) begin
							count_q <= count_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (first || in_c > peak_q) begin
							peak_q  <= in_c;
							peakt_q <= in_t;
						end
						prevt_q <= in_t;
						prevl_q <= in_c;
						scan_q  <= '0;
						mean_q  <= '0;
						var_q   <= '0;
						recov_q <= '0;
						if (!first) begin
							state_q <= (dt_now != 32'd0 && csum_now != 33'd0) ? ST_P0 : ST_REC;
						end else if (s_tlast) begin
							state_q <= ST_SCAN_RD;
						end
					end
				end
				ST_P0: begin
					if (mul_rsp.done) begin
						issued_q <= 1'b0;
						p0_q     <= mul_val;
						m0_q     <= acc_val;
						ovf_q    <= ovf_q | mul_sat | acc_sat;
						state_q  <= (tsum_q != 33'd0) ? ST_P1 : ST_REC;
					end
				end
				ST_P1: begin
					if (mul_rsp.done) begin
						issued_q <= 1'b0;
						p1_q     <= mul_val;
						m1_q     <= acc_val;
						ovf_q    <= ovf_q | mul_sat | acc_sat;
						state_q  <= ST_P2;
					end
				end
				ST_P2: begin
					if (mul_rsp.done) begin
						issued_q <= 1'b0;
						m2_q     <= acc_val;
						ovf_q    <= ovf_q | mul_sat | acc_sat;
						state_q  <= ST_REC;
					end
				end
				ST_REC: begin
					if (mul_rsp.done) begin
						issued_q <= 1'b0;
						rsum_q   <= acc_val;
						ovf_q    <= ovf_q | mul_sat | acc_sat;
						state_q  <= last_q ? ST_SCAN_RD : ST_IDLE;
					end
				end
				ST_SCAN_RD: begin
					state_q <= ST_SCAN_CHK;
				end
				ST_SCAN_CHK: begin
					if (scan_q == '0 || hit) begin
						arrival_q <= rd_time_q;
					end
					if (hit || (scan_q + CW'(1)) == count_q) begin
						if (m0_q != 64'd0) begin
							state_q <= ST_DIV_MEAN;
						end else begin
							state_q <= (mass_q != 32'd0) ? ST_DIV_REC : ST_OUT;
						end
					end else begin
						scan_q  <= scan_q + CW'(1);
						state_q <= ST_SCAN_RD;
					end
				end
				ST_DIV_MEAN: begin
					if (div_rsp.done) begin
						issued_q <= 1'b0;
						if (div_rsp.over || (|q_half[62:48])) begin
							mean_q <= MAX48;
							ovf_q  <= 1'b1;
						end else begin
							mean_q <= q_half[47:0];
						end
						state_q <= ST_DIV_E2;
					end
				end
				ST_DIV_E2: begin
					if (div_rsp.done) begin
						issued_q <= 1'b0;
						if (div_rsp.over) begin
							e2_q  <= MAX64;
							ovf_q <= 1'b1;
						end else begin
							e2_q <= {2'd0, div_rsp.quot[63:2]};
						end
						state_q <= ST_MSQ;
					end
				end
				ST_MSQ: begin
					if (mul_rsp.done) begin
						issued_q <= 1'b0;
						var_q    <= var_now;
						ovf_q    <= ovf_q | msq_sat | var_sat;
						state_q  <= (mass_q != 32'd0) ? ST_DIV_REC : ST_OUT;
					end
				end
				ST_DIV_REC: begin
					if (div_rsp.done) begin
						issued_q <= 1'b0;
						if (div_rsp.over || (|div_rsp.quot[63:32])) begin
							recov_q <= 32'hFFFF_FFFF;
							ovf_q   <= 1'b1;
						end else begin
							recov_q <= div_rsp.quot[31:0];
						end
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						m_tdata  <= {7'd0, ovf_q, recov_q, var_q, mean_q,
							peakt_q, peak_q, arrival_q};
						count_q  <= '0;
						m0_q     <= '0;
						m1_q     <= '0;
						m2_q     <= '0;
						rsum_q   <= '0;
						peak_q   <= '0;
						peakt_q  <= '0;
						prevt_q  <= '0;
						prevl_q  <= '0;
						ovf_q    <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// sample store: write on accept while the store has room, registered read for the scan
	always_ff @(posedge clk) begin
		if (accept && store_ok) begin
			time_mem[count_q[AW-1:0]]  <= in_t;
			level_mem[count_q[AW-1:0]] <= in_c;
		end
		rd_time_q  <= time_mem[scan_q[AW-1:0]];
		rd_level_q <= level_mem[scan_q[AW-1:0]];
	end

	bcm_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	bcm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

endmodule

`default_nettype wire

FILE: hdl/bcm_checker.sv
// ----------------------------------------------------------------------------
// bcm_checker
// Port-level checks for the moments unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "breakthrough_curve_moments_unit_defines.svh"

module bcm_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_tvalid,
	input wire logic         s_tready,
	input wire logic         s_tlast,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [247:0] m_tdata
);

	// a stalled result beat stays up and holds its data
	`BCM_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid)
	`BCM_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata))
	// a final sample keeps the block busy for its closing pass
	`BCM_ASSERT_NEXT(a_last_busy, s_tvalid && s_tready && s_tlast, !s_tready)
	// a new result only appears right after the busy closing pass
	`BCM_ASSERT_IMPLY(a_result_after_pass, $rose(m_tvalid), $past(!s_tready))

endmodule

bind breakthrough_curve_moments_unit bcm_checker u_bcm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

FILE: test/tb_breakthrough_curve_moments_unit.sv
// ----------------------------------------------------------------------------
// Breakthrough curve moments unit testbench
// Sends tracer curves through the sample stream, predicts each summary beat
// (arrival, peak, trapezoid mean and variance, recovery, overflow) and checks
// every result field in order. Runs under several injected mass settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_breakthrough_curve_moments_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] INT64_TOP = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] INT64_BOT = 64'h8000_0000_0000_0000;
	localparam logic [63:0] Q48_TOP = 64'h0000_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic [31:0] arrival_time;
		logic [31:0] peak_level;
		logic [31:0] peak_at;
		logic [47:0] mean_time;
		logic [63:0] time_variance;
		logic [31:0] recovery;
		logic        overflow;
	} summary_t;

	// curve predictor and queue of expected summaries
	class curve_scoreboard;
		logic [31:0] mass;
		logic [31:0] t_mem[bcm_pkg::SAMPLE_DEPTH];
		logic [31:0] c_mem[bcm_pkg::SAMPLE_DEPTH];
		int          count;
		logic [63:0] m0, m1, m2, rec;
		logic [31:0] pk_val, pk_time, last_t, last_c;
		bit          ovf, sat;
		summary_t    pending_q[$];
		int          errors;

		function new();
			mass = bcm_pkg::MASS_RESET;
			errors = 0;
			clear_curve();
		endfunction

		function void clear_curve();
			count = 0;
			m0 = 0; m1 = 0; m2 = 0; rec = 0;
			pk_val = 0; pk_time = 0; last_t = 0; last_c = 0;
			ovf = 0;
		endfunction

		function logic [63:0] smul(logic [63:0] a, logic [63:0] b);
			logic [127:0] p;
			p = a * b;
			if (p[127:64] != 0) begin
				sat = 1;
				return ALL_ONES;
			end
			return p[63:0];
		endfunction

		function logic [63:0] sadd(logic [63:0] a, logic [63:0] b);
			logic [64:0] s;
			s = {1'b0, a} + {1'b0, b};
			if (s[64]) begin
				sat = 1;
				return ALL_ONES;
			end
			return s[63:0];
		endfunction

		// floor(num * 2^16 / den), clamped to 64 bits
		function logic [63:0] div_q16(logic [63:0] num, logic [63:0] den, output bit over);
			logic [127:0] q;
			q = {48'b0, num, 16'b0} / {64'b0, den};
			over = (q[127:64] != 0);
			return over ? ALL_ONES : q[63:0];
		endfunction

		function int pending();
			return pending_q.size();
		endfunction

		function void note_sample(logic [31:0] t, logic [31:0] c, bit is_last);
			bit first, s2, dsat;
			logic [63:0] dt, csum, tsum, p0, p1, p2, mean, e2, msq, var_q, d, recov;
			logic [127:0] sq;
			summary_t r;
			first = (count == 0);
			sat = 0;
			if (!first) begin
				dt = (t >= last_t) ? 64'(t - last_t) : 64'd0;
				csum = 64'(c) + 64'(last_c);
				tsum = 64'(t) + 64'(last_t);
				if (dt != 0 && csum != 0) begin
					p0 = smul(csum, dt);
					m0 = sadd(m0, p0);
					if (tsum != 0) begin
						p1 = smul(p0, tsum);
						p2 = smul(p1, tsum);
						m1 = sadd(m1, p1);
						m2 = sadd(m2, p2);
					end
				end
				rec = sadd(rec, 64'(c) * dt);
			end
			if (sat) ovf = 1;
			if (count < bcm_pkg::SAMPLE_DEPTH) begin
				t_mem[count] = t;
				c_mem[count] = c;
				count++;
			end else begin
				ovf = 1;
			end
			if (first || c > pk_val) begin
				pk_val = c;
				pk_time = t;
			end
			last_t = t;
			last_c = c;
			if (!is_last) return;

			// end of curve: arrival scan and final scaling
			sat = ovf;
			r.arrival_time = t_mem[0];
			for (int i = 0; i < count; i++) begin
				if (64'(c_mem[i]) * 64'd100 > 64'(pk_val)) begin
					r.arrival_time = t_mem[i];
					break;
				end
			end
			mean = 0;
			var_q = 0;
			if (m0 != 0) begin
				mean = div_q16(m1, m0, dsat) >> 1;
				if (dsat) sat = 1;
				if (mean > Q48_TOP) begin
					mean = Q48_TOP;
					sat = 1;
				end
				e2 = div_q16(m2, m0, s2);
				if (s2) sat = 1;
				else e2 = e2 >> 2;
				sq = mean * mean;
				if (sq[127:80] != 0) begin
					msq = ALL_ONES;
					sat = 1;
				end else begin
					msq = sq[79:16];
				end
				if (e2 >= msq) begin
					var_q = e2 - msq;
					if (var_q > INT64_TOP) begin
						var_q = INT64_TOP;
						sat = 1;
					end
				end else begin
					d = msq - e2;
					if (d > INT64_BOT) begin
						d = INT64_BOT;
						sat = 1;
					end
					var_q = 64'd0 - d;
				end
			end
			recov = 0;
			if (mass != 0) begin
				recov = div_q16(rec, 64'(mass), dsat);
				if (dsat) sat = 1;
				if (recov > 64'hFFFF_FFFF) begin
					recov = 64'hFFFF_FFFF;
					sat = 1;
				end
			end
			r.peak_level = pk_val;
			r.peak_at = pk_time;
			r.mean_time = mean[47:0];
			r.time_variance = var_q;
			r.recovery = recov[31:0];
			r.overflow = sat;
			pending_q = {pending_q, r};
			clear_curve();
		endfunction

		task report(string what, logic [63:0] got, logic [63:0] want);
			errors++;
			$display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
		endtask

		task check_result(logic [247:0] data);
			summary_t w;
			if (pending_q.size() == 0) begin
				report("unexpected result beat", 64'(data[31:0]), 64'd0);
				return;
			end
			w = pending_q.pop_front();
			if (data[31:0] !== w.arrival_time)
				report("arrival_time", 64'(data[31:0]), 64'(w.arrival_time));
			if (data[63:32] !== w.peak_level)
				report("peak_level", 64'(data[63:32]), 64'(w.peak_level));
			if (data[95:64] !== w.peak_at)
				report("peak_at", 64'(data[95:64]), 64'(w.peak_at));
			if (data[143:96] !== w.mean_time)
				report("mean_time", 64'(data[143:96]), 64'(w.mean_time));
			if (data[207:144] !== w.time_variance)
				report("time_variance", data[207:144], w.time_variance);
			if (data[239:208] !== w.recovery)
				report("recovery", 64'(data[239:208]), 64'(w.recovery));
			if (data[240] !== w.overflow)
				report("overflow", 64'(data[240]), 64'(w.overflow));
			if (data[247:241] !== 7'd0)
				report("pad bits", 64'(data[247:241]), 64'd0);
		endtask
	endclass

	logic         clk = 0;
	logic         arst_n = 0;
	logic         cfg_valid = 0;
	logic         cfg_ready;
	logic [31:0]  cfg_data = 0;
	logic         s_tvalid = 0;
	logic         s_tready;
	logic [63:0]  s_tdata = 0;	// [31:0] sample_time, [63:32] concentration
	logic         s_tlast = 0;
	logic         m_tvalid;
	logic         m_tready = 0;
	logic [247:0] m_tdata;	// arrival, peak_level, peak_at, mean, variance, recovery, overflow

	bit calm = 0;
	curve_scoreboard curve = new();

	breakthrough_curve_moments_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #5 clk = ~clk;

	// result side: random backpressure, check each taken beat
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) curve.check_result(m_tdata);
			m_tready <= calm || ($urandom_range(99) >= 22);
		end
	end

	task automatic send_sample(input logic [31:0] t, input logic [31:0] c, input bit is_last);
		if (!calm && $urandom_range(99) < 22) begin
			s_tvalid <= 0;
			do @(posedge clk); while (!calm && $urandom_range(99) < 22);
		end
		s_tvalid <= 1;
		s_tdata <= {c, t};
		s_tlast <= is_last;
		do @(posedge clk); while (!s_tready);
		curve.note_sample(t, c, is_last);
	endtask

	// mass register written only with the unit drained
	task automatic write_mass(input logic [31:0] v);
		s_tvalid <= 0;
		while (curve.pending() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		cfg_valid <= 1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		curve.mass = v;
	endtask

	function automatic logic [31:0] pick_level();
		int sel;
		sel = $urandom_range(99);
		if (sel < 55) return $urandom_range(32'h40000, 0);
		if (sel < 75) return $urandom();
		if (sel < 87) return 32'd0;
		return $urandom_range(5, 0);
	endfunction

	task automatic random_curve(input int len);
		logic [31:0] t;
		int sel;
		sel = $urandom_range(3);
		t = (sel == 0) ? 32'd0 : (sel == 1) ? $urandom_range(5000, 0) :
			(sel == 2) ? $urandom() : 32'hFFFF_FFFF - $urandom_range(20000, 0);
		for (int i = 0; i < len; i++) begin
			send_sample(t, pick_level(), i == len - 1);
			sel = $urandom_range(99);
			if (sel < 5) t = t - $urandom_range(100, 1);	// step back in time
			else if (sel < 9) t = t + $urandom();
			else t = t + $urandom_range(60, 0);
		end
	endtask

	initial begin
		#20ms;
		$display("simulation failed");
		$finish;
	end

	initial begin
		logic [31:0] masses[5];
		int len, budget;
		masses = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd0, bcm_pkg::MASS_RESET};
		masses[3] = $urandom();
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// single sample curve at the top of both fields: zero moment
		send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
		// ramp, time step backward, drop to zero
		send_sample(32'd0, 32'd0, 0);
		send_sample(32'd10, 32'h0001_0000, 0);
		send_sample(32'd5, 32'h0003_0000, 0);
		send_sample(32'd20, 32'h0003_0000, 0);
		send_sample(32'd30, 32'd0, 1);
		// products saturate into the accumulators
		send_sample(32'd0, 32'hFFFF_FFFF, 0);
		send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
		send_sample(32'hFFFF_FFFF, 32'd1, 1);
		// all zero levels
		send_sample(32'd100, 32'd0, 0);
		send_sample(32'd200, 32'd0, 0);
		send_sample(32'd300, 32'd0, 1);
		// nothing above one percent except the peak, late arrival
		send_sample(32'd1, 32'd1, 0);
		send_sample(32'd2, 32'd100, 0);
		send_sample(32'd3, 32'd101, 0);
		send_sample(32'd4, 32'h7FFF_FFFF, 0);
		send_sample(32'd4, 32'h7FFF_FFFF, 1);
		// time zero throughout with nonzero levels
		send_sample(32'd0, 32'h0001_0000, 0);
		send_sample(32'd0, 32'h0002_0000, 1);

		// random curves under each mass setting
		for (int ph = 0; ph < 5; ph++) begin
			write_mass(masses[ph]);
			budget = 100;
			if (ph == 2) begin
				// one curve longer than the store
				random_curve(bcm_pkg::SAMPLE_DEPTH + $urandom_range(6, 1));
			end
			while (budget > 0) begin
				calm = (ph == 1 && budget < 60);
				len = ($urandom_range(99) < 85) ? $urandom_range(12, 1) :
					$urandom_range(60, 13);
				random_curve(len);
				budget -= len;
			end
			calm = 0;
		end
		s_tvalid <= 0;
		while (curve.pending() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (curve.errors == 0 && curve.pending() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
